@@ design/poly_pkg.sv @@
// Shared types and constants of the polynomial evaluator.
package poly_pkg;

    // Field widths
    localparam int X_W      = 32;
    localparam int VAL_W    = 48;
    localparam int DEG_W    = 3;
    localparam int ADDR_W   = 3;
    localparam int NUM_COEF = 6;
    localparam int SPLIT_W  = VAL_W / 2;

    // Saturation limits of the 48-bit value
    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    // Register map of the configuration port
    typedef enum logic [ADDR_W-1:0] {
        REG_DEGREE = 3'd0,
        REG_COEF0  = 3'd1,
        REG_COEF1  = 3'd2,
        REG_COEF2  = 3'd3,
        REG_COEF3  = 3'd4,
        REG_COEF4  = 3'd5,
        REG_COEF5  = 3'd6
    } t_cfg_reg;

    // Item state handed from cell to cell
    typedef struct packed {
        logic                    valid;
        logic                    sat;
        logic signed [X_W-1:0]   x;
        logic signed [VAL_W-1:0] power;
        logic signed [VAL_W-1:0] acc;
    } t_side;

    // Item state inside a cell once the new power is known
    typedef struct packed {
        t_side                   side;
        logic signed [VAL_W-1:0] power;
        logic                    psat;
    } t_mid;

endpackage

@@ design/polynomial_evaluator.sv @@
// Top level: configuration registers and the chain of power cells.
//
//  channel  dir  fields (lowest bit first)            beat taken when
//  s_axis   in   tdata: x_in[31:0]                     tvalid & tready
//  m_axis   out  tdata: poly_value[47:0]; tuser: sat   tvalid & tready
//  cfg      in   addr: register index; wr_data         wr_en
//
//  One cell per power 1..MAX_DEGREE, each seven registers deep (two three-stage
//  multipliers and an accumulate stage).
//  A new x is taken every cycle; all cells advance in lock step.
//  When an output beat stalls, the whole chain holds and tready drops.
//  Synchronous reset clears all beats in flight and the configuration registers to zero.
module polynomial_evaluator #(
    parameter int MAX_DEGREE = 5,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_wr_en,
    input  logic [poly_pkg::ADDR_W-1:0]         i_cfg_addr,
    input  logic [poly_pkg::X_W-1:0]            i_cfg_wr_data,
    // input stream
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [poly_pkg::X_W-1:0]            i_s_axis_tdata,   // x_in[31:0]
    // output stream
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [poly_pkg::VAL_W-1:0]          o_m_axis_tdata,   // poly_value[47:0]
    output logic [0:0]                          o_m_axis_tuser    // saturated[0]
);

    logic [poly_pkg::DEG_W-1:0]          r_degree;
    logic signed [poly_pkg::X_W-1:0]     r_coef [0:poly_pkg::NUM_COEF-1];
    logic [poly_pkg::DEG_W-1:0]          deg_eff;
    logic [poly_pkg::ADDR_W-1:0]         coef_idx;
    logic                                en;
    poly_pkg::t_side                     chain [0:MAX_DEGREE];

    // Write the configuration registers; unknown indexes are dropped
    assign coef_idx = i_cfg_addr - poly_pkg::REG_COEF0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree <= '0;
            for (int i = 0; i < poly_pkg::NUM_COEF; i++) begin
                r_coef[i] <= '0;
            end
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                poly_pkg::REG_DEGREE: begin
                    r_degree <= i_cfg_wr_data[poly_pkg::DEG_W-1:0];
                end
                default: begin
                    if (i_cfg_addr inside {[poly_pkg::REG_COEF0:poly_pkg::REG_COEF5]}) begin
                        r_coef[coef_idx] <= i_cfg_wr_data;
                    end
                end
            endcase
        end
    end

    // Clamp degree to the number of cells
    assign deg_eff = (r_degree > poly_pkg::DEG_W'(MAX_DEGREE))
                   ? poly_pkg::DEG_W'(MAX_DEGREE) : r_degree;

    // Advance the chain unless the output beat is stalled
    assign en              = !chain[MAX_DEGREE].valid || i_m_axis_tready;
    assign o_s_axis_tready = en;

    // Seed the chain: power 1.0, accumulator at the constant coefficient
    always_comb begin
        chain[0].valid = i_s_axis_tvalid;
        chain[0].sat   = 1'b0;
        chain[0].x     = i_s_axis_tdata;
        chain[0].power = poly_pkg::VAL_W'(1) <<< FRAC_BITS;
        chain[0].acc   = poly_pkg::VAL_W'(r_coef[0]);
    end

    // One cell per power
    for (genvar k = 1; k <= MAX_DEGREE; k++) begin : g_cell
        logic signed [poly_pkg::X_W-1:0] coef;
        logic                            active;

        if (k < poly_pkg::NUM_COEF) begin : g_reg
            assign coef = r_coef[k];
        end else begin : g_zero
            assign coef = '0;
        end

        assign active = poly_pkg::DEG_W'(k) <= deg_eff;

        poly_cell #(.FRAC_BITS(FRAC_BITS)) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (en),
            .i_active (active),
            .i_coef   (coef),
            .i_side   (chain[k-1]),
            .o_side   (chain[k])
        );
    end

    // Drive the output beat from the last cell
    assign o_m_axis_tvalid   = chain[MAX_DEGREE].valid;
    assign o_m_axis_tdata    = chain[MAX_DEGREE].acc;
    assign o_m_axis_tuser[0] = chain[MAX_DEGREE].sat;

endmodule

@@ design/poly_mul_round.sv @@
// Three-stage 48x32 signed multiplier with half-up rounding and 48-bit saturation.
module poly_mul_round #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [poly_pkg::VAL_W-1:0]   i_a,
    input  logic signed [poly_pkg::X_W-1:0]     i_b,
    output logic signed [poly_pkg::VAL_W-1:0]   o_p,
    output logic                                o_sat
);

    localparam int SPLIT  = poly_pkg::SPLIT_W;
    localparam int PROD_W = poly_pkg::VAL_W + poly_pkg::X_W;
    localparam int HI_W   = (poly_pkg::VAL_W - SPLIT) + poly_pkg::X_W;
    localparam int LO_W   = SPLIT + 1 + poly_pkg::X_W;
    localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [PROD_W-1:0] LIM_MAX = PROD_W'(poly_pkg::VAL_MAX);
    localparam logic signed [PROD_W-1:0] LIM_MIN = PROD_W'(poly_pkg::VAL_MIN);

    logic signed [poly_pkg::VAL_W-SPLIT-1:0] hi_a;
    logic signed [SPLIT:0]                   lo_a;
    logic signed [HI_W-1:0]                  n_hi, r_hi;
    logic signed [LO_W-1:0]                  n_lo, r_lo;
    logic signed [PROD_W-1:0]                n_sum, r_sum;
    logic signed [PROD_W-1:0]                rnd;
    logic signed [poly_pkg::VAL_W-1:0]       n_p, r_p;
    logic                                    n_sat, r_sat;

    // Split the 48-bit operand into a signed upper and an unsigned lower half
    assign hi_a = i_a[poly_pkg::VAL_W-1:SPLIT];
    assign lo_a = {1'b0, i_a[SPLIT-1:0]};

    // Stage 1: two partial products
    always_comb begin
        n_hi = HI_W'(hi_a) * HI_W'(i_b);
        n_lo = LO_W'(lo_a) * LO_W'(i_b);
    end

    // Stage 2: combine partials and add the rounding half
    assign n_sum = (PROD_W'(r_hi) <<< SPLIT) + PROD_W'(r_lo) + HALF;

    // Stage 3: drop fraction bits and clamp to 48 bits
    always_comb begin
        rnd   = r_sum >>> FRAC_BITS;
        n_sat = 1'b0;
        n_p   = rnd[poly_pkg::VAL_W-1:0];
        if (rnd > LIM_MAX) begin
            n_sat = 1'b1;
            n_p   = poly_pkg::VAL_MAX;
        end else if (rnd < LIM_MIN) begin
            n_sat = 1'b1;
            n_p   = poly_pkg::VAL_MIN;
        end
    end

    // Advance all stages together
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hi  <= n_hi;
            r_lo  <= n_lo;
            r_sum <= n_sum;
            r_p   <= n_p;
            r_sat <= n_sat;
        end
    end

    assign o_p   = r_p;
    assign o_sat = r_sat;

endmodule

@@ design/poly_cell.sv @@
// One power step of the chain: new power, term and accumulate, seven stages deep.
module poly_cell #(
    parameter int FRAC_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_active,
    input  logic signed [poly_pkg::X_W-1:0]   i_coef,
    input  poly_pkg::t_side                   i_side,
    output poly_pkg::t_side                   o_side
);

    localparam int MUL_LAT = 3;

    poly_pkg::t_side                    r_d1 [0:MUL_LAT-1];
    poly_pkg::t_mid                     r_d2 [0:MUL_LAT-1];
    poly_pkg::t_mid                     n_mid;
    poly_pkg::t_side                    n_out, r_out;
    logic signed [poly_pkg::VAL_W-1:0]  pw_new;
    logic                               pw_sat;
    logic signed [poly_pkg::VAL_W-1:0]  term;
    logic                               term_sat;
    logic signed [poly_pkg::VAL_W:0]    sum;
    logic signed [poly_pkg::VAL_W-1:0]  acc_new;
    logic                               acc_ovf;

    // power * x
    poly_mul_round #(.FRAC_BITS(FRAC_BITS)) u_mul_pow (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_a   (i_side.power),
        .i_b   (i_side.x),
        .o_p   (pw_new),
        .o_sat (pw_sat)
    );

    // new power * coefficient
    poly_mul_round #(.FRAC_BITS(FRAC_BITS)) u_mul_term (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_a   (pw_new),
        .i_b   (i_coef),
        .o_p   (term),
        .o_sat (term_sat)
    );

    // Join the new power to the item once it leaves the first multiplier
    always_comb begin
        n_mid.side  = r_d1[MUL_LAT-1];
        n_mid.power = pw_new;
        n_mid.psat  = pw_sat;
    end

    // Accumulate with saturation; an idle cell passes the item through
    always_comb begin
        sum     = {r_d2[MUL_LAT-1].side.acc[poly_pkg::VAL_W-1], r_d2[MUL_LAT-1].side.acc}
                + {term[poly_pkg::VAL_W-1], term};
        acc_ovf = sum[poly_pkg::VAL_W] != sum[poly_pkg::VAL_W-1];
        if (acc_ovf) begin
            acc_new = sum[poly_pkg::VAL_W] ? poly_pkg::VAL_MIN : poly_pkg::VAL_MAX;
        end else begin
            acc_new = sum[poly_pkg::VAL_W-1:0];
        end
        n_out = r_d2[MUL_LAT-1].side;
        if (i_active) begin
            n_out.power = r_d2[MUL_LAT-1].power;
            n_out.acc   = acc_new;
            n_out.sat   = r_d2[MUL_LAT-1].side.sat | r_d2[MUL_LAT-1].psat
                        | term_sat | acc_ovf;
        end
    end

    // Delay the item alongside both multipliers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MUL_LAT; i++) begin
                r_d1[i].valid      <= 1'b0;
                r_d2[i].side.valid <= 1'b0;
            end
            r_out.valid <= 1'b0;
        end else if (i_en) begin
            r_d1[0] <= i_side;
            r_d2[0] <= n_mid;
            for (int i = 1; i < MUL_LAT; i++) begin
                r_d1[i] <= r_d1[i-1];
                r_d2[i] <= r_d2[i-1];
            end
            r_out <= n_out;
        end
    end

    assign o_side = r_out;

endmodule

@@ design/poly_checker.sv @@
// Port-level checks of the polynomial evaluator and their binding.
module poly_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    input  logic                          o_s_axis_tready,
    input  logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    input  logic [poly_pkg::VAL_W-1:0]    o_m_axis_tdata,
    input  logic [0:0]                    o_m_axis_tuser
);

    // Input is taken exactly when the output side can move
    a_ready_follows_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready == (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("input ready does not follow output backpressure");

    // A stalled output beat holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled output beat changed");

    // Reset empties the chain
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");

    // While stalled, no new beat can be taken at the input
    a_no_take_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |-> !(i_s_axis_tvalid && o_s_axis_tready))
        else $error("input beat taken while output stalled");

endmodule

bind polynomial_evaluator poly_checker u_poly_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
